// ===== hdl/ray_sphere_intersect_core_macros.svh =====
// Assertion macros used by the checker file.
`ifndef RAY_SPHERE_INTERSECT_CORE_MACROS_SVH
`define RAY_SPHERE_INTERSECT_CORE_MACROS_SVH

// Same-cycle implication, quiet while reset is held
`define RSI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet while reset is held
`define RSI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Condition that must hold in the cycle after reset is sampled low
`define RSI_ASSERT_RESET(label, clk, rst_n, cons, msg) \
  label: assert property (@(posedge clk) !rst_n |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/rsi_pkg.sv =====
`timescale 1ns / 1ps

package rsi_pkg;

  // Configuration register map
  localparam int CFG_ADDR_W = 2;
  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

  localparam cfg_addr_t CFG_CENTER_X  = 2'd0;
  localparam cfg_addr_t CFG_CENTER_Y  = 2'd1;
  localparam cfg_addr_t CFG_CENTER_Z  = 2'd2;
  localparam cfg_addr_t CFG_RADIUS_SQ = 2'd3;

  // Root bits resolved in each stage of the square-root pipeline
  localparam int SQRT_STEPS_PER_STAGE = 2;

endpackage

// ===== hdl/rsi_sqrt.sv =====
`timescale 1ns / 1ps

// Pipelined digit-by-digit integer square root, floor(sqrt(rad)).
// Each stage resolves SQRT_STEPS_PER_STAGE root bits; a sideband word
// travels alongside. Per-stage valid bits with bubble-collapsing enables.
module rsi_sqrt #(
  parameter int RAD_W  = 49,
  parameter int SIDE_W = 33
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [RAD_W-1:0]          in_rad,
  input  logic [SIDE_W-1:0]         in_side,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [(RAD_W+RAD_W%2)/2-1:0] out_root,
  output logic [SIDE_W-1:0]         out_side
);

  localparam int EVEN_W = RAD_W + (RAD_W % 2);
  localparam int ROOT_W = EVEN_W / 2;
  localparam int SPS    = rsi_pkg::SQRT_STEPS_PER_STAGE;
  localparam int NSTG   = (ROOT_W + SPS - 1) / SPS;

  logic [NSTG-1:0]   vld_r;
  logic [NSTG-1:0]   vld_nxt;
  logic [NSTG-1:0]   en;

  logic [ROOT_W+1:0] rem_r   [NSTG];
  logic [ROOT_W-1:0] root_r  [NSTG];
  logic [EVEN_W-1:0] rad_r   [NSTG];
  logic [SIDE_W-1:0] side_r  [NSTG];

  logic [ROOT_W+1:0] rem_i   [NSTG+1];
  logic [ROOT_W-1:0] root_i  [NSTG+1];
  logic [EVEN_W-1:0] rad_i   [NSTG+1];
  logic [SIDE_W-1:0] side_i  [NSTG+1];

  logic [ROOT_W+1:0] rem_nxt  [NSTG];
  logic [ROOT_W-1:0] root_nxt [NSTG];
  logic [EVEN_W-1:0] rad_nxt  [NSTG];

  // Stage enables: a stage moves when empty or when the next one moves
  always_comb begin
    en[NSTG-1] = ~vld_r[NSTG-1] | out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = ~vld_r[k] | en[k+1];
    end
  end

  assign vld_nxt   = {vld_r[NSTG-2:0], in_valid};
  assign in_ready  = en[0];
  assign out_valid = vld_r[NSTG-1];

  // Stage inputs: slot 0 is the new radicand, slot k+1 is stage k
  always_comb begin
    rem_i[0]  = '0;
    root_i[0] = '0;
    rad_i[0]  = EVEN_W'(in_rad);
    side_i[0] = in_side;
    for (int k = 0; k < NSTG; k++) begin
      rem_i[k+1]  = rem_r[k];
      root_i[k+1] = root_r[k];
      rad_i[k+1]  = rad_r[k];
      side_i[k+1] = side_r[k];
    end
  end

  // Restoring root steps: bring down two bits, try (root << 2) | 1
  always_comb begin
    logic [ROOT_W+1:0] rem_t;
    logic [ROOT_W-1:0] root_t;
    logic [EVEN_W-1:0] rad_t;
    logic [ROOT_W+1:0] trial;
    for (int k = 0; k < NSTG; k++) begin
      rem_t  = rem_i[k];
      root_t = root_i[k];
      rad_t  = rad_i[k];
      trial  = '0;
      for (int j = 0; j < SPS; j++) begin
        if (k * SPS + j < ROOT_W) begin
          rem_t = {rem_t[ROOT_W-1:0], rad_t[EVEN_W-1 -: 2]};
          rad_t = {rad_t[EVEN_W-3:0], 2'b00};
          trial = {root_t, 2'b01};
          if (rem_t >= trial) begin
            rem_t  = rem_t - trial;
            root_t = {root_t[ROOT_W-2:0], 1'b1};
          end else begin
            root_t = {root_t[ROOT_W-2:0], 1'b0};
          end
        end
      end
      rem_nxt[k]  = rem_t;
      root_nxt[k] = root_t;
      rad_nxt[k]  = rad_t;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_nxt[k];
        end
      end
    end
  end

  // Stage payload
  always_ff @(posedge clk) begin
    for (int k = 0; k < NSTG; k++) begin
      if (en[k]) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
        rad_r[k]  <= rad_nxt[k];
        side_r[k] <= side_i[k];
      end
    end
  end

  assign out_root = root_i[NSTG];
  assign out_side = side_i[NSTG];

endmodule

// ===== hdl/ray_sphere_intersect_core.sv =====
`timescale 1ns / 1ps
// Throughput: one ray per cycle while out_tready holds; eight arithmetic stages,
//   the root pipeline (two root bits per stage, RW = ceil((COORD_WIDTH + 1 + FRAC_BITS) / 2)
//   root bits in all) and an output register, all with valid bits.
// Reset (rst_n low, synchronous) empties the pipeline, sets the center to 0
//   and radius_sq to 1.0.
module ray_sphere_intersect_core #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // configuration
  input  logic                                   cfg_wr_en,
  input  rsi_pkg::cfg_addr_t                     cfg_addr,
  input  logic [COORD_WIDTH-1:0]                 cfg_wdata,
  // rays in
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (lowest first), zero pad
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]     in_tdata,
  // results out
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // t_near, t_far (lowest first), zero pad
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0]     out_tdata,
  // hit
  output logic [0:0]                             out_tuser
);

  localparam int W      = COORD_WIDTH;
  localparam int F      = FRAC_BITS;
  localparam int OUT_W  = ((2 * COORD_WIDTH + 7) / 8) * 8;
  localparam int NPRE   = 8;
  localparam int RAD_W  = W + 1 + F;
  localparam int ROOT_W = (RAD_W + RAD_W % 2) / 2;
  localparam int SUM_W  = ((ROOT_W > W) ? ROOT_W : W) + 2;
  localparam int SIDE_W = W + 1;

  // Saturate a wide signed value to the coordinate range
  function automatic logic signed [W-1:0] sat_w(input logic signed [SUM_W-1:0] v);
    logic [SUM_W-W:0]     hi;
    logic signed [W-1:0]  r;
    hi = v[SUM_W-1:W-1];
    if ((&hi) || !(|hi)) begin
      r = v[W-1:0];
    end else if (v[SUM_W-1]) begin
      r = {1'b1, {(W-1){1'b0}}};
    end else begin
      r = {1'b0, {(W-1){1'b1}}};
    end
    return r;
  endfunction

  // Fixed-point product: magnitude >> F, saturated, sign restored
  function automatic logic signed [W-1:0] fmul_sat(input logic signed [2*W-1:0] p);
    logic            neg;
    logic [2*W-1:0]  mag;
    logic [2*W-1:0]  sh;
    logic [2*W-1:0]  lim;
    logic [W-1:0]    r;
    neg = p[2*W-1];
    mag = neg ? (2*W)'(-p) : (2*W)'(p);
    sh  = mag >> F;
    lim = neg ? ((2*W)'(1) << (W - 1)) : (((2*W)'(1) << (W - 1)) - 1'b1);
    r   = (sh > lim) ? lim[W-1:0] : sh[W-1:0];
    return neg ? -$signed(r) : $signed(r);
  endfunction

  // Configuration registers
  logic signed [W-1:0] ctr_r [3];
  logic [W-1:0]        r2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r[0] <= '0;
      ctr_r[1] <= '0;
      ctr_r[2] <= '0;
      r2_r     <= {{(W-1){1'b0}}, 1'b1} << F;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        rsi_pkg::CFG_CENTER_X:  ctr_r[0] <= cfg_wdata;
        rsi_pkg::CFG_CENTER_Y:  ctr_r[1] <= cfg_wdata;
        rsi_pkg::CFG_CENTER_Z:  ctr_r[2] <= cfg_wdata;
        rsi_pkg::CFG_RADIUS_SQ: r2_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pipeline control for the arithmetic stages
  logic [NPRE-1:0] vld_r;
  logic [NPRE-1:0] vld_nxt;
  logic [NPRE-1:0] en_pre;
  logic            sq_in_ready;
  logic            sq_out_valid;
  logic            out_en;

  assign out_en = ~out_tvalid | out_tready;

  always_comb begin
    en_pre[NPRE-1] = ~vld_r[NPRE-1] | sq_in_ready;
    for (int k = NPRE - 2; k >= 0; k--) begin
      en_pre[k] = ~vld_r[k] | en_pre[k+1];
    end
  end

  assign vld_nxt   = {vld_r[NPRE-2:0], in_tvalid};
  assign in_tready = en_pre[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < NPRE; k++) begin
        if (en_pre[k]) begin
          vld_r[k] <= vld_nxt[k];
        end
      end
    end
  end

  // Unpack the ray
  logic signed [W-1:0] org [3];
  logic signed [W-1:0] dir [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      org[i] = in_tdata[i*W +: W];
      dir[i] = in_tdata[(i+3)*W +: W];
    end
  end

  // Stage 0: L = center - origin, saturated
  logic signed [W-1:0] la_r [3];
  logic signed [W-1:0] da_r [3];

  always_ff @(posedge clk) begin
    if (en_pre[0]) begin
      for (int i = 0; i < 3; i++) begin
        la_r[i] <= sat_w(SUM_W'(ctr_r[i]) - SUM_W'(org[i]));
        da_r[i] <= dir[i];
      end
    end
  end

  // Stage 1: raw products L*D and L*L
  logic signed [2*W-1:0] pdb_r [3];
  logic signed [2*W-1:0] plb_r [3];

  always_ff @(posedge clk) begin
    if (en_pre[1]) begin
      for (int i = 0; i < 3; i++) begin
        pdb_r[i] <= la_r[i] * da_r[i];
        plb_r[i] <= la_r[i] * la_r[i];
      end
    end
  end

  // Stage 2: scale and saturate each product
  logic signed [W-1:0] mdc_r [3];
  logic signed [W-1:0] mlc_r [3];

  always_ff @(posedge clk) begin
    if (en_pre[2]) begin
      for (int i = 0; i < 3; i++) begin
        mdc_r[i] <= fmul_sat(pdb_r[i]);
        mlc_r[i] <= fmul_sat(plb_r[i]);
      end
    end
  end

  // Stage 3: dot products tca = L.D and ll = L.L
  logic signed [W-1:0] tca_d_r;
  logic signed [W-1:0] ll_d_r;

  always_ff @(posedge clk) begin
    if (en_pre[3]) begin
      tca_d_r <= sat_w(SUM_W'(mdc_r[0]) + SUM_W'(mdc_r[1]) + SUM_W'(mdc_r[2]));
      ll_d_r  <= sat_w(SUM_W'(mlc_r[0]) + SUM_W'(mlc_r[1]) + SUM_W'(mlc_r[2]));
    end
  end

  // Stage 4: raw tca * tca
  logic signed [2*W-1:0] ttp_e_r;
  logic signed [W-1:0]   tca_e_r;
  logic signed [W-1:0]   ll_e_r;

  always_ff @(posedge clk) begin
    if (en_pre[4]) begin
      ttp_e_r <= tca_d_r * tca_d_r;
      tca_e_r <= tca_d_r;
      ll_e_r  <= ll_d_r;
    end
  end

  // Stage 5: scale tca^2
  logic signed [W-1:0] tt_f_r;
  logic signed [W-1:0] tca_f_r;
  logic signed [W-1:0] ll_f_r;

  always_ff @(posedge clk) begin
    if (en_pre[5]) begin
      tt_f_r  <= fmul_sat(ttp_e_r);
      tca_f_r <= tca_e_r;
      ll_f_r  <= ll_e_r;
    end
  end

  // Stage 6: d2 = L.L - tca^2
  logic signed [W-1:0] d2_g_r;
  logic signed [W-1:0] tca_g_r;

  always_ff @(posedge clk) begin
    if (en_pre[6]) begin
      d2_g_r  <= sat_w(SUM_W'(ll_f_r) - SUM_W'(tt_f_r));
      tca_g_r <= tca_f_r;
    end
  end

  // Stage 7: hit test (tca >= 0 and d2 <= r2; negative d2 passes) and root argument r2 - d2
  logic [W+1:0]        dd;
  logic                hit_h_r;
  logic [W:0]          diff_h_r;
  logic signed [W-1:0] tca_h_r;

  assign dd = {2'b00, r2_r} - (W+2)'(d2_g_r);

  always_ff @(posedge clk) begin
    if (en_pre[7]) begin
      hit_h_r  <= ~tca_g_r[W-1] & ~dd[W+1];
      diff_h_r <= dd[W:0];
      tca_h_r  <= tca_g_r;
    end
  end

  // Root pipeline: thc = floor(sqrt((r2 - d2) << F))
  logic [ROOT_W-1:0]   sq_root;
  logic [SIDE_W-1:0]   sq_side;
  logic signed [W-1:0] sq_tca;
  logic                sq_hit;

  rsi_sqrt #(
    .RAD_W  (RAD_W),
    .SIDE_W (SIDE_W)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vld_r[NPRE-1]),
    .in_ready  (sq_in_ready),
    .in_rad    ({diff_h_r, {F{1'b0}}}),
    .in_side   ({hit_h_r, tca_h_r}),
    .out_valid (sq_out_valid),
    .out_ready (out_en),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  assign sq_tca = sq_side[W-1:0];
  assign sq_hit = sq_side[W];

  // Output register: t_near / t_far, zero on a miss
  logic                out_tvalid_r;
  logic                out_hit_r;
  logic signed [W-1:0] t_near_r;
  logic signed [W-1:0] t_far_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_en) begin
      out_tvalid_r <= sq_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_hit_r <= sq_hit;
      if (sq_hit) begin
        t_near_r <= sat_w(SUM_W'(sq_tca) - SUM_W'(sq_root));
        t_far_r  <= sat_w(SUM_W'(sq_tca) + SUM_W'(sq_root));
      end else begin
        t_near_r <= '0;
        t_far_r  <= '0;
      end
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = OUT_W'({t_far_r, t_near_r});
  assign out_tuser  = out_hit_r;

endmodule

// ===== hdl/rsi_checker.sv =====
`timescale 1ns / 1ps
`include "ray_sphere_intersect_core_macros.svh"

// Port-level checks on the result channel
module rsi_checker #(
  parameter int COORD_WIDTH = 32
) (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               out_tvalid,
  input logic                               out_tready,
  input logic [((2*COORD_WIDTH+7)/8)*8-1:0] out_tdata,
  input logic [0:0]                         out_tuser
);

  localparam int W = COORD_WIDTH;

  // A stalled result stays put
  `RSI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // A miss carries zero distances
  `RSI_ASSERT_NOW(a_miss_zero, clk, rst_n, out_tvalid && !out_tuser[0], out_tdata == '0, "miss with nonzero distances")

  // On a hit the entry point never lies past the exit point, and exit is ahead
  `RSI_ASSERT_NOW(a_hit_order, clk, rst_n, out_tvalid && out_tuser[0], ($signed(out_tdata[W-1:0]) <= $signed(out_tdata[2*W-1:W])) && !out_tdata[2*W-1], "t_near after t_far or t_far negative")

  // Reset leaves no result valid
  `RSI_ASSERT_RESET(a_reset_empty, clk, rst_n, !out_tvalid, "result valid right after reset")

endmodule

bind ray_sphere_intersect_core rsi_checker #(
  .COORD_WIDTH (COORD_WIDTH)
) u_rsi_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
